// ----- design/assert_macros.svh -----
// Assertion macros shared by the neighbor finder RTL.
// No dependencies; pulled in by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ltnf_pkg.sv -----
// Shared constants, register codes and the command word for the neighbor finder.
// No dependencies; used by every module of the block except the RAM.
`timescale 1ns / 1ps

package ltnf_pkg;

  localparam int MAX_NODES    = 64;
  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_CHILDREN = 63;
  localparam int CHILD_W      = $clog2(MAX_CHILDREN + 1);
  localparam int QUEUE_DEPTH  = 2;

  localparam int RANK_W = 6;
  localparam int CFG_W  = 7;
  localparam int NODE_W = 7;

  localparam logic [CFG_W-1:0] STEP_LAG_RST   = 7'd1;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [0:0] {
    REG_STEP_LAG   = 1'b0,
    REG_NODE_COUNT = 1'b1
  } cfg_reg_e;

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic              bad;
    logic [RANK_W-1:0] rank;
    logic [CFG_W-1:0]  lag;    // already forced to at least 1
    logic [CFG_W-1:0]  count;  // already clamped to the node limit
  } cmd_t;

endpackage

// ----- design/lame_tree_neighbour_finder_unit.sv -----
// A bad rank goes straight to its word; a good rank first rebuilds the whole table, then
// reads it for the start-level scan and for each level walked by senders up to the rank;
// a start scan or level walk may run past the end of the table.
// The back end takes one word at a time; the two-entry queue takes a new word while not full.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset (rst_ni, async, active low): step_lag 1, node_count 64, queue empty, back idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Top level of the neighbor finder for a Lame broadcast tree.
//
// Front (ltnf_front): holds the two configuration registers, forces a zero
// lag to 1, clamps node_count to MaxNodes and flags ranks at or above the
// clamped count. Each accepted word is pushed as a command word into a short
// queue (ltnf_fifo); busy is simply "queue full", so the front keeps taking
// words while the back end is still walking the tree.
//
// Back (ltnf_back): per command it rebuilds the ready-count table r(t) in a
// single-port-read RAM (for each entry: read r(t-lag), then write),
// then walks senders 0..rank. A monotone pointer gives each sender's start
// level; each level costs one table read to find the receiver. Children of
// the rank are strobed out in increasing order as they are found, the parent
// word (clamped count+1 for the root, 0 for an orphan) closes the run with last.
// A flagged rank skips all of that and gives one word with bad_rank set.

module lame_tree_neighbour_finder_unit #(
  parameter int MaxNodes   = ltnf_pkg::MAX_NODES,
  parameter int TableDepth = ltnf_pkg::TABLE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [ltnf_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        start,
  input  logic [ltnf_pkg::RANK_W-1:0] node_rank_i,
  output logic                        busy,
  output logic                        result_valid_o,
  output logic                        is_parent_o,
  output logic [ltnf_pkg::NODE_W-1:0] node_o,
  output logic                        last_o,
  output logic                        bad_rank_o
);

  ltnf_pkg::cmd_t front_cmd;
  ltnf_pkg::cmd_t queue_cmd;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  ltnf_front #(
    .MaxNodes (MaxNodes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start),
    .node_rank_i (node_rank_i),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  ltnf_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  ltnf_back #(
    .MaxNodes   (MaxNodes),
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (!empty),
    .cmd_i          (queue_cmd),
    .cmd_pop_o      (pop),
    .result_valid_o (result_valid_o),
    .is_parent_o    (is_parent_o),
    .node_o         (node_o),
    .last_o         (last_o),
    .bad_rank_o     (bad_rank_o)
  );

  assign busy = full;

  // a flagged rank gives exactly one closing word with node 0
  `ASSERT_IMPL(a_bad_word_form, clk_i, rst_ni, result_valid_o && bad_rank_o, last_o && !is_parent_o && node_o == '0, "bad rank word malformed")
  // child words never close a run
  `ASSERT_IMPL(a_child_not_last, clk_i, rst_ni, result_valid_o && !is_parent_o && !bad_rank_o, !last_o, "child word marked last")
  // the parent word always closes a run of a valid rank
  `ASSERT_IMPL(a_parent_is_last, clk_i, rst_ni, result_valid_o && is_parent_o, last_o && !bad_rank_o, "parent word not last")
  // the back end gives no word in the cycle right after a closing word
  `ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni, result_valid_o && last_o, !result_valid_o, "word right after last")

endmodule

// ----- design/ltnf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the ready-count table.
`timescale 1ns / 1ps

module ltnf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ltnf_fifo.sv -----
// Short command queue between the front and the back of the neighbor finder.
// Depends on ltnf_pkg for the command word and the queue depth.
`timescale 1ns / 1ps

module ltnf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ltnf_pkg::cmd_t   cmd_i,
  input  logic             pop_i,
  output ltnf_pkg::cmd_t   cmd_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int Depth = ltnf_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

  ltnf_pkg::cmd_t  slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   fill_q, fill_d;

  assign full_o  = (fill_q == (PtrW + 1)'(Depth));
  assign empty_o = (fill_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/ltnf_front.sv -----
// Front end: configuration registers, request accept and rank classification.
// Depends on ltnf_pkg for register codes, reset values and the command word.
`timescale 1ns / 1ps

module ltnf_front #(
  parameter int MaxNodes = ltnf_pkg::MAX_NODES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [ltnf_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            start_i,
  input  logic [ltnf_pkg::RANK_W-1:0]     node_rank_i,
  input  logic                            full_i,
  output logic                            push_o,
  output ltnf_pkg::cmd_t                  cmd_o
);

  localparam int CountCap = (MaxNodes < 127) ? MaxNodes : 127;

  logic [ltnf_pkg::CFG_W-1:0] step_lag_q;
  logic [ltnf_pkg::CFG_W-1:0] node_count_q;
  logic [ltnf_pkg::CFG_W-1:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_lag_q   <= ltnf_pkg::STEP_LAG_RST;
      node_count_q <= ltnf_pkg::NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (ltnf_pkg::cfg_reg_e'(cfg_idx_i))
        ltnf_pkg::REG_STEP_LAG:   step_lag_q   <= cfg_wdata_i;
        ltnf_pkg::REG_NODE_COUNT: node_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero lag behaves as lag 1; count is clamped to the node limit
  assign count = (node_count_q > ltnf_pkg::CFG_W'(CountCap)) ?
                 ltnf_pkg::CFG_W'(CountCap) : node_count_q;

  assign push_o      = start_i && !full_i;
  assign cmd_o.lag   = (step_lag_q == '0) ? ltnf_pkg::CFG_W'(1) : step_lag_q;
  assign cmd_o.count = count;
  assign cmd_o.rank  = node_rank_i;
  assign cmd_o.bad   = ({1'b0, node_rank_i} >= count);

endmodule

// ----- design/ltnf_back.sv -----
// Back end: rebuilds the ready-count table, walks senders and levels, emits words.
// Depends on ltnf_pkg and ltnf_ram.
`timescale 1ns / 1ps

module ltnf_back #(
  parameter int MaxNodes   = ltnf_pkg::MAX_NODES,
  parameter int TableDepth = ltnf_pkg::TABLE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  ltnf_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output logic                        result_valid_o,
  output logic                        is_parent_o,
  output logic [ltnf_pkg::NODE_W-1:0] node_o,
  output logic                        last_o,
  output logic                        bad_rank_o
);

  localparam int RdW   = $clog2(MaxNodes + 2);
  localparam int AddrW = $clog2(TableDepth);
  localparam int TW    = AddrW + 1;
  localparam int IdxW  = $clog2(TableDepth + 128) + 1;
  localparam int SumW  = ((RdW > 7) ? RdW : 7) + 1;
  localparam int CmpW  = (TW > 7) ? TW : 7;
  localparam int NW    = ltnf_pkg::NODE_W;
  localparam int ChW   = ltnf_pkg::CHILD_W;

  localparam logic [RdW-1:0] SatVal = RdW'(MaxNodes + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_BUILD_RD = 9'b000000010,
    S_BUILD_WR = 9'b000000100,
    S_SCAN     = 9'b000001000,
    S_SCAN_CHK = 9'b000010000,
    S_LVL      = 9'b000100000,
    S_LVL_CHK  = 9'b001000000,
    S_PARENT   = 9'b010000000,
    S_BAD      = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  ltnf_pkg::cmd_t  cmd_q, cmd_d;
  logic [TW-1:0]   t_q, t_d;
  logic [RdW-1:0]  prev_q, prev_d;
  logic [TW-1:0]   st_q, st_d;
  logic [6:0]      sender_q, sender_d;
  logic [IdxW-1:0] lvl_q, lvl_d;
  logic [ChW-1:0]  child_q, child_d;
  logic [NW-1:0]   parent_q, parent_d;

  logic            valid_q, valid_d;
  logic            is_par_q, is_par_d;
  logic [NW-1:0]   node_q, node_d;
  logic            last_q, last_d;
  logic            bad_q, bad_d;

  logic [RdW-1:0]  rd_data;
  logic [AddrW-1:0] raddr;
  logic            we;

  logic [CmpW-1:0] t_ext, k_ext, bld_addr;
  logic            t_lt_k;
  logic [RdW:0]    bsum;
  logic [RdW-1:0]  bval;
  logic [IdxW-1:0] idx;
  logic            idx_oob;
  logic            st_end;
  logic [SumW-1:0] recv;
  logic            scan_hit;
  logic            sender_done;

  // table build: r(t) = 1 below the lag, else r(t-1) + r(t-lag), saturating
  assign t_ext    = CmpW'(t_q);
  assign k_ext    = CmpW'(cmd_q.lag);
  assign t_lt_k   = t_ext < k_ext;
  assign bld_addr = t_ext - k_ext;
  assign bsum     = {1'b0, prev_q} + {1'b0, rd_data};
  assign bval     = t_lt_k ? RdW'(1) :
                    ((bsum > (RdW + 1)'(MaxNodes)) ? SatVal : bsum[RdW-1:0]);

  // search: level index lvl + lag - 1; beyond the table it reads as saturated
  assign idx      = lvl_q + IdxW'(cmd_q.lag) - IdxW'(1);
  assign idx_oob  = idx >= IdxW'(TableDepth);
  assign st_end   = st_q == TW'(TableDepth);
  assign recv     = SumW'(sender_q) + SumW'(rd_data);
  assign scan_hit = SumW'(rd_data) > SumW'(sender_q);

  assign we = (state_q == S_BUILD_WR);

  always_comb begin
    case (state_q)
      S_BUILD_RD: raddr = bld_addr[AddrW-1:0];
      S_SCAN:     raddr = st_q[AddrW-1:0];
      S_LVL:      raddr = idx[AddrW-1:0];
      default:    raddr = '0;
    endcase
  end

  ltnf_ram #(
    .Width (RdW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (t_q[AddrW-1:0]),
    .wdata_i (bval),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    t_d         = t_q;
    prev_d      = prev_q;
    st_d        = st_q;
    sender_d    = sender_q;
    lvl_d       = lvl_q;
    child_d     = child_q;
    parent_d    = parent_q;
    valid_d     = 1'b0;
    is_par_d    = is_par_q;
    node_d      = node_q;
    last_d      = last_q;
    bad_d       = bad_q;
    cmd_pop_o   = 1'b0;
    sender_done = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          t_d       = '0;
          state_d   = cmd_i.bad ? S_BAD : S_BUILD_RD;
        end
      end
      S_BUILD_RD: begin
        state_d = S_BUILD_WR;
      end
      S_BUILD_WR: begin
        prev_d = bval;
        t_d    = t_q + 1'b1;
        if (t_q == TW'(TableDepth - 1)) begin
          st_d     = '0;
          sender_d = '0;
          child_d  = '0;
          parent_d = (cmd_q.rank == '0) ? NW'(cmd_q.count + 1'b1) : '0;
          state_d  = S_SCAN;
        end else begin
          state_d = S_BUILD_RD;
        end
      end
      S_SCAN: begin
        // start level is monotone in the sender, so the pointer only moves up
        if (st_end) begin
          lvl_d   = IdxW'(st_q);
          state_d = S_LVL;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (scan_hit) begin
          lvl_d   = IdxW'(st_q);
          state_d = S_LVL;
        end else begin
          st_d    = st_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_LVL: begin
        if (idx_oob) begin
          sender_done = 1'b1;
        end else begin
          state_d = S_LVL_CHK;
        end
      end
      S_LVL_CHK: begin
        if (recv >= SumW'(cmd_q.count)) begin
          sender_done = 1'b1;
        end else if (recv == SumW'(cmd_q.rank)) begin
          parent_d    = sender_q;
          sender_done = 1'b1;
        end else begin
          if (sender_q == {1'b0, cmd_q.rank} &&
              child_q < ChW'(ltnf_pkg::MAX_CHILDREN)) begin
            valid_d  = 1'b1;
            is_par_d = 1'b0;
            node_d   = recv[NW-1:0];
            last_d   = 1'b0;
            bad_d    = 1'b0;
            child_d  = child_q + 1'b1;
          end
          lvl_d   = lvl_q + 1'b1;
          state_d = S_LVL;
        end
      end
      S_PARENT: begin
        valid_d  = 1'b1;
        is_par_d = 1'b1;
        node_d   = parent_q;
        last_d   = 1'b1;
        bad_d    = 1'b0;
        state_d  = S_IDLE;
      end
      S_BAD: begin
        valid_d  = 1'b1;
        is_par_d = 1'b0;
        node_d   = '0;
        last_d   = 1'b1;
        bad_d    = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // only lower senders can reach the rank, so the walk ends at the rank
    if (sender_done) begin
      if (sender_q == {1'b0, cmd_q.rank}) begin
        state_d = S_PARENT;
      end else begin
        sender_d = sender_q + 1'b1;
        state_d  = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    t_q      <= t_d;
    prev_q   <= prev_d;
    st_q     <= st_d;
    sender_q <= sender_d;
    lvl_q    <= lvl_d;
    child_q  <= child_d;
    parent_q <= parent_d;
    is_par_q <= is_par_d;
    node_q   <= node_d;
    last_q   <= last_d;
    bad_q    <= bad_d;
  end

  assign result_valid_o = valid_q;
  assign is_parent_o    = is_par_q;
  assign node_o         = node_q;
  assign last_o         = last_q;
  assign bad_rank_o     = bad_q;

endmodule
